// File: src/tlik_pkg.sv
package tlik_pkg;

	localparam int TABLE_LEN = 24;
	localparam int ANGLE_W = 28;
	localparam int Q14_BITS = 15;

	localparam logic signed [ANGLE_W-1:0] PI_Q24 = 28'sd52707179;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;

	function automatic logic [23:0] atan_q24(input int i);
		case (i)
			0: return 24'd13176795;
			1: return 24'd7778716;
			2: return 24'd4110060;
			3: return 24'd2086331;
			4: return 24'd1047214;
			5: return 24'd524117;
			6: return 24'd262123;
			7: return 24'd131069;
			8: return 24'd65536;
			9: return 24'd32768;
			10: return 24'd16384;
			11: return 24'd8192;
			12: return 24'd4096;
			13: return 24'd2048;
			14: return 24'd1024;
			15: return 24'd512;
			16: return 24'd256;
			17: return 24'd128;
			18: return 24'd64;
			19: return 24'd32;
			20: return 24'd16;
			21: return 24'd8;
			22: return 24'd4;
			23: return 24'd2;
			default: return 24'd0;
		endcase
	endfunction

endpackage

// File: src/tlik_sincos.sv
module tlik_sincos #(
	parameter int STEPS = 16,
	parameter int SW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic signed [14:0] angle,
	input logic [SW-1:0] in_side,
	output logic out_valid,
	output logic signed [32:0] sin_q30,
	output logic signed [32:0] cos_q30,
	output logic [SW-1:0] out_side
);

	localparam int N = (STEPS > tlik_pkg::TABLE_LEN) ? tlik_pkg::TABLE_LEN : STEPS;
	localparam int AW = tlik_pkg::ANGLE_W;

	logic signed [AW-1:0] z_in;
	logic vld_s [0:N];
	logic flip_s [0:N];
	logic signed [32:0] x_s [0:N];
	logic signed [32:0] y_s [0:N];
	logic signed [AW-1:0] z_s [0:N];
	logic [SW-1:0] side_s [0:N];

	assign z_in = $signed({{(AW-27){angle[14]}}, angle, 12'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= $signed({3'b0, tlik_pkg::GAIN_INV_Q30});
		y_s[0] <= '0;
		side_s[0] <= in_side;
		if (z_in > tlik_pkg::HALF_PI_Q24) begin
			z_s[0] <= z_in - tlik_pkg::PI_Q24;
			flip_s[0] <= 1'b1;
		end else if (z_in < -tlik_pkg::HALF_PI_Q24) begin
			z_s[0] <= z_in + tlik_pkg::PI_Q24;
			flip_s[0] <= 1'b1;
		end else begin
			z_s[0] <= z_in;
			flip_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [AW-1:0] ATAN =
			$signed({{(AW-24){1'b0}}, tlik_pkg::atan_q24(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			side_s[i+1] <= side_s[i];
			if (!z_s[i][AW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		sin_q30 <= flip_s[N] ? -y_s[N] : y_s[N];
		cos_q30 <= flip_s[N] ? -x_s[N] : x_s[N];
		out_side <= side_s[N];
	end

endmodule

// File: src/tlik_isqrt.sv
module tlik_isqrt #(
	parameter int W = 32,
	parameter int SW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [W-1:0] in_value,
	input logic [SW-1:0] in_side,
	output logic out_valid,
	output logic [W/2-1:0] root,
	output logic [SW-1:0] out_side
);

	localparam int N = W / 2;

	logic vld_s [1:N];
	logic [W:0] rem_s [1:N];
	logic [W:0] res_s [1:N];
	logic [SW-1:0] side_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2 * k);
		logic [W:0] rem_c;
		logic [W:0] res_c;
		logic [W:0] trial_c;
		logic vld_c;
		logic [SW-1:0] side_c;

		if (k == 0) begin : g_first
			assign rem_c = {1'b0, in_value};
			assign res_c = '0;
			assign vld_c = in_valid;
			assign side_c = in_side;
		end else begin : g_next
			assign rem_c = rem_s[k];
			assign res_c = res_s[k];
			assign vld_c = vld_s[k];
			assign side_c = side_s[k];
		end

		assign trial_c = res_c + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_c;
			if (rem_c >= trial_c) begin
				rem_s[k+1] <= rem_c - trial_c;
				res_s[k+1] <= (res_c >> 1) + BIT;
			end else begin
				rem_s[k+1] <= rem_c;
				res_s[k+1] <= res_c >> 1;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign root = res_s[N][N-1:0];
	assign out_side = side_s[N];

endmodule

// File: src/tlik_div.sv
module tlik_div #(
	parameter int DW = 33,
	parameter int SW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [DW-1:0] mag,
	input logic [DW-1:0] den,
	input logic [SW-1:0] in_side,
	output logic out_valid,
	output logic [tlik_pkg::Q14_BITS-1:0] quot,
	output logic [SW-1:0] out_side
);

	localparam int QB = tlik_pkg::Q14_BITS;

	logic vld_s [1:QB];
	logic [DW-1:0] rem_s [1:QB];
	logic [DW-1:0] den_s [1:QB];
	logic [QB-1:0] q_s [1:QB];
	logic [SW-1:0] side_s [1:QB];

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [DW:0] t_c;
		logic [DW-1:0] den_c;
		logic [QB-1:0] q_c;
		logic vld_c;
		logic [SW-1:0] side_c;

		if (j == 0) begin : g_first
			assign t_c = {1'b0, mag};
			assign den_c = den;
			assign q_c = '0;
			assign vld_c = in_valid;
			assign side_c = in_side;
		end else begin : g_next
			assign t_c = {rem_s[j], 1'b0};
			assign den_c = den_s[j];
			assign q_c = q_s[j];
			assign vld_c = vld_s[j];
			assign side_c = side_s[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			den_s[j+1] <= den_c;
			side_s[j+1] <= side_c;
			if (t_c >= {1'b0, den_c}) begin
				rem_s[j+1] <= DW'(t_c - {1'b0, den_c});
				q_s[j+1] <= {q_c[QB-2:0], 1'b1};
			end else begin
				rem_s[j+1] <= t_c[DW-1:0];
				q_s[j+1] <= {q_c[QB-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign quot = q_s[QB];
	assign out_side = side_s[QB];

endmodule

// File: src/tlik_vecang.sv
module tlik_vecang #(
	parameter int STEPS = 16,
	parameter int IW = 16,
	parameter int SW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic signed [IW-1:0] u,
	input logic signed [IW-1:0] v,
	input logic [SW-1:0] in_side,
	output logic out_valid,
	output logic signed [15:0] ang,
	output logic [SW-1:0] out_side
);

	localparam int N = (STEPS > tlik_pkg::TABLE_LEN) ? tlik_pkg::TABLE_LEN : STEPS;
	localparam int AW = tlik_pkg::ANGLE_W;
	localparam int DW = IW + 17;

	logic signed [DW-1:0] us_c;
	logic signed [DW-1:0] vs_c;
	logic vld_s [0:N];
	logic signed [DW-1:0] a_s [0:N];
	logic signed [DW-1:0] b_s [0:N];
	logic signed [AW-1:0] z_s [0:N];
	logic [SW-1:0] side_s [0:N];
	logic vld_p1_s;
	logic neg_p1_s;
	logic [AW-1:0] mag_p1_s;
	logic [SW-1:0] side_p1_s;
	logic [AW-1:0] rnd_c;
	logic [15:0] r_c;

	assign us_c = DW'($signed({u, 14'b0}));
	assign vs_c = DW'($signed({v, 14'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		if (us_c < 0) begin
			a_s[0] <= -us_c;
			b_s[0] <= -vs_c;
			z_s[0] <= (vs_c >= 0) ? tlik_pkg::PI_Q24 : -tlik_pkg::PI_Q24;
		end else begin
			a_s[0] <= us_c;
			b_s[0] <= vs_c;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [AW-1:0] ATAN =
			$signed({{(AW-24){1'b0}}, tlik_pkg::atan_q24(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (!b_s[i][DW-1]) begin
				a_s[i+1] <= a_s[i] + (b_s[i] >>> i);
				b_s[i+1] <= b_s[i] - (a_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN;
			end else begin
				a_s[i+1] <= a_s[i] - (b_s[i] >>> i);
				b_s[i+1] <= b_s[i] + (a_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN;
			end
		end
	end

	// Round Q24 to Q12, half away from zero.
	assign rnd_c = mag_p1_s + AW'(2048);
	assign r_c = rnd_c[AW-1:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1_s <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_p1_s <= vld_s[N];
			out_valid <= vld_p1_s;
		end
	end

	always_ff @(posedge clk) begin
		neg_p1_s <= z_s[N][AW-1];
		mag_p1_s <= z_s[N][AW-1] ? AW'(-z_s[N]) : AW'(z_s[N]);
		side_p1_s <= side_s[N];
		ang <= neg_p1_s ? -$signed(r_c) : $signed(r_c);
		out_side <= side_p1_s;
	end

endmodule

// File: src/two_link_arm_inverse_kinematics.sv
// Two-link planar arm inverse kinematics solver.
// A target (target_x, target_y, target_heading) is taken at a rising edge where start
// is high and busy is low; busy stays low, so a new target may be given every cycle.
// The wrist point is the target moved back along the heading by the tool length, and
// the shoulder and elbow angles follow from the law of cosines.
// Each result beat appears on shoulder_angle, elbow_angle and reach_status for exactly
// one cycle, marked by done. The receiver cannot stall the block and need not.
// The path runs through two chains of CORDIC stages (CORDIC_STEPS capped at 24), the
// two square-root pipelines and the quotient pipeline, with registered steps between.
// Throughput is one beat per cycle; results leave in the order targets arrived.
// Link and tool lengths are written through wr_en, wr_index and wr_data; the user must
// write them only while no target is in flight, which the block does not enforce. Reset
// clears all valid bits and loads the default lengths of 256, 512 and 128.
module two_link_arm_inverse_kinematics #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] target_x,
	input logic signed [15:0] target_y,
	input logic signed [14:0] target_heading,
	input logic wr_en,
	input logic [1:0] wr_index,
	input logic [15:0] wr_data,
	output logic done,
	output logic signed [15:0] shoulder_angle,
	output logic [13:0] elbow_angle,
	output logic [1:0] reach_status
);

	localparam logic [1:0] REG_UPPER = 2'd0;
	localparam logic [1:0] REG_LOWER = 2'd1;
	localparam logic [1:0] REG_TOOL = 2'd2;
	localparam logic signed [15:0] PI_Q12 = 16'sd12868;
	localparam logic [15:0] ONE_Q14 = 16'd16384;
	localparam logic [28:0] ONE_SQ = 29'd268435456;

	typedef enum logic [1:0] {
		REACH_OK = 2'd0,
		REACH_CLAMPED = 2'd1,
		REACH_ORIGIN = 2'd2
	} reach_t;

	typedef struct packed {
		logic signed [15:0] tx;
		logic signed [15:0] ty;
	} sc_side_t;

	typedef struct packed {
		logic signed [15:0] wx;
		logic signed [15:0] wy;
		logic origin;
		logic [31:0] r2;
	} rt_side_t;

	typedef struct packed {
		logic neg;
		logic over;
		logic dz;
		logic signed [15:0] wx;
		logic signed [15:0] wy;
		logic origin;
	} db_side_t;

	typedef struct packed {
		logic neg;
		logic over;
		logic dz;
	} dg_side_t;

	typedef struct packed {
		logic signed [15:0] c;
		logic signed [15:0] wx;
		logic signed [15:0] wy;
		logic origin;
		logic over;
	} sb_side_t;

	typedef struct packed {
		logic signed [15:0] c;
		logic over;
	} sg_side_t;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'sd32767;
		end else if (v < -20'sd32768) begin
			return -16'sd32768;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		if (v < lo) begin
			return lo;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic logic signed [15:0] arg_q14(input logic [14:0] q, input logic neg,
			input logic over, input logic dz);
		logic [15:0] m;
		m = over ? ONE_Q14 : (dz ? 16'd0 : {1'b0, q});
		return neg ? -$signed(m) : $signed(m);
	endfunction

	logic [15:0] upper_q;
	logic [15:0] lower_q;
	logic [15:0] tool_q;

	sc_side_t sc_in;
	sc_side_t sc_out;
	logic sc_valid;
	logic signed [32:0] sin_q30;
	logic signed [32:0] cos_q30;

	logic vld_s1;
	logic signed [49:0] ps_s1;
	logic signed [49:0] pc_s1;
	sc_side_t tgt_s1;
	logic signed [49:0] rs_c;
	logic signed [49:0] rc_c;

	logic vld_s2;
	logic signed [19:0] dx_s2;
	logic signed [19:0] dy_s2;
	sc_side_t tgt_s2;

	logic vld_s3;
	logic signed [15:0] wx_s3;
	logic signed [15:0] wy_s3;

	logic vld_s4;
	logic signed [31:0] sqx_c;
	logic signed [31:0] sqy_c;
	logic [31:0] sqx_s4;
	logic [31:0] sqy_s4;
	logic signed [15:0] wx_s4;
	logic signed [15:0] wy_s4;
	logic origin_s4;

	logic vld_s5;
	rt_side_t rt_in;

	logic rt_valid;
	logic [15:0] rt_root;
	rt_side_t rt_out;

	logic vld_s6;
	logic [31:0] l1r_s6;
	logic [31:0] l1sq_s6;
	logic [31:0] l2sq_s6;
	logic [31:0] l1l2_s6;
	rt_side_t side_s6;

	logic vld_s7;
	logic signed [34:0] numb_s7;
	logic signed [34:0] numg_s7;
	logic [32:0] denb_s7;
	logic [32:0] deng_s7;
	rt_side_t side_s7;

	logic vld_s8;
	logic negb_s8;
	logic negg_s8;
	logic [33:0] magb_s8;
	logic [33:0] magg_s8;
	logic [32:0] denb_s8;
	logic [32:0] deng_s8;
	rt_side_t side_s8;

	logic vld_s9;
	logic [32:0] dmb_s9;
	logic [32:0] dmg_s9;
	logic [32:0] denb_s9;
	logic [32:0] deng_s9;
	db_side_t db_in;
	dg_side_t dg_in;

	logic db_valid;
	logic dg_valid;
	logic [14:0] qb;
	logic [14:0] qg;
	db_side_t db_out;
	dg_side_t dg_out;

	logic vld_s10;
	logic signed [15:0] cb_s10;
	logic signed [15:0] cg_s10;
	db_side_t side_s10;
	logic over_g_s10;

	logic vld_s11;
	logic signed [31:0] csqb_c;
	logic signed [31:0] csqg_c;
	logic [28:0] csqb_s11;
	logic [28:0] csqg_s11;
	logic signed [15:0] cb_s11;
	logic signed [15:0] cg_s11;
	db_side_t side_s11;
	logic over_g_s11;

	logic vld_s12;
	sb_side_t sb_in;
	sg_side_t sg_in;
	logic [28:0] radb_s12;
	logic [28:0] radg_s12;

	logic sb_valid;
	logic sg_valid;
	logic [14:0] sb_root;
	logic [14:0] sg_root;
	sb_side_t sb_out;
	sg_side_t sg_out;

	logic va_valid;
	logic vb_valid;
	logic vg_valid;
	logic signed [15:0] alpha_ang;
	logic signed [15:0] beta_ang;
	logic signed [15:0] gamma_ang;
	logic va_origin;
	logic vb_over;
	logic vg_over;

	logic vld_s13;
	logic signed [15:0] alpha_s13;
	logic signed [15:0] beta_s13;
	logic signed [15:0] gamma_s13;
	logic origin_s13;
	logic clamped_s13;
	logic signed [15:0] elbow_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 16'd256;
			lower_q <= 16'd512;
			tool_q <= 16'd128;
		end else if (wr_en) begin
			case (wr_index)
				REG_UPPER: upper_q <= wr_data;
				REG_LOWER: lower_q <= wr_data;
				REG_TOOL: tool_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign sc_in.tx = target_x;
	assign sc_in.ty = target_y;

	tlik_sincos #(
		.STEPS(CORDIC_STEPS),
		.SW($bits(sc_side_t))
	) u_sincos (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start & ~busy),
		.angle(target_heading),
		.in_side(sc_in),
		.out_valid(sc_valid),
		.sin_q30(sin_q30),
		.cos_q30(cos_q30),
		.out_side(sc_out)
	);

	assign rs_c = ps_s1 + 50'sd536870912;
	assign rc_c = pc_s1 + 50'sd536870912;
	assign sqx_c = wx_s3 * wx_s3;
	assign sqy_c = wy_s3 * wy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= sc_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ps_s1 <= $signed({1'b0, tool_q}) * sin_q30;
		pc_s1 <= $signed({1'b0, tool_q}) * cos_q30;
		tgt_s1 <= sc_out;
		dx_s2 <= rs_c[49:30];
		dy_s2 <= rc_c[49:30];
		tgt_s2 <= tgt_s1;
		wx_s3 <= sat16({{4{tgt_s2.tx[15]}}, tgt_s2.tx} - dx_s2);
		wy_s3 <= sat16({{4{tgt_s2.ty[15]}}, tgt_s2.ty} - dy_s2);
		sqx_s4 <= sqx_c;
		sqy_s4 <= sqy_c;
		wx_s4 <= wx_s3;
		wy_s4 <= wy_s3;
		origin_s4 <= (wx_s3 == 16'sd0) && (wy_s3 == 16'sd0);
		rt_in.wx <= wx_s4;
		rt_in.wy <= wy_s4;
		rt_in.origin <= origin_s4;
		rt_in.r2 <= sqx_s4 + sqy_s4;
	end

	tlik_isqrt #(
		.W(32),
		.SW($bits(rt_side_t))
	) u_radius (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s5),
		.in_value(rt_in.r2),
		.in_side(rt_in),
		.out_valid(rt_valid),
		.root(rt_root),
		.out_side(rt_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s6 <= rt_valid;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		l1r_s6 <= upper_q * rt_root;
		l1sq_s6 <= upper_q * upper_q;
		l2sq_s6 <= lower_q * lower_q;
		l1l2_s6 <= upper_q * lower_q;
		side_s6 <= rt_out;

		numb_s7 <= $signed({3'b0, l1sq_s6}) + $signed({3'b0, side_s6.r2})
			- $signed({3'b0, l2sq_s6});
		numg_s7 <= $signed({3'b0, l1sq_s6}) + $signed({3'b0, l2sq_s6})
			- $signed({3'b0, side_s6.r2});
		denb_s7 <= {l1r_s6, 1'b0};
		deng_s7 <= {l1l2_s6, 1'b0};
		side_s7 <= side_s6;

		negb_s8 <= numb_s7[34];
		negg_s8 <= numg_s7[34];
		magb_s8 <= numb_s7[34] ? 34'(-numb_s7) : numb_s7[33:0];
		magg_s8 <= numg_s7[34] ? 34'(-numg_s7) : numg_s7[33:0];
		denb_s8 <= denb_s7;
		deng_s8 <= deng_s7;
		side_s8 <= side_s7;

		db_in.neg <= negb_s8;
		db_in.over <= magb_s8 > {1'b0, denb_s8};
		db_in.dz <= denb_s8 == '0;
		db_in.wx <= side_s8.wx;
		db_in.wy <= side_s8.wy;
		db_in.origin <= side_s8.origin;
		dg_in.neg <= negg_s8;
		dg_in.over <= magg_s8 > {1'b0, deng_s8};
		dg_in.dz <= deng_s8 == '0;
		dmb_s9 <= (magb_s8 > {1'b0, denb_s8}) ? '0 : magb_s8[32:0];
		dmg_s9 <= (magg_s8 > {1'b0, deng_s8}) ? '0 : magg_s8[32:0];
		denb_s9 <= denb_s8;
		deng_s9 <= deng_s8;
	end

	tlik_div #(
		.DW(33),
		.SW($bits(db_side_t))
	) u_div_beta (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s9),
		.mag(dmb_s9),
		.den(denb_s9),
		.in_side(db_in),
		.out_valid(db_valid),
		.quot(qb),
		.out_side(db_out)
	);

	tlik_div #(
		.DW(33),
		.SW($bits(dg_side_t))
	) u_div_gamma (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s9),
		.mag(dmg_s9),
		.den(deng_s9),
		.in_side(dg_in),
		.out_valid(dg_valid),
		.quot(qg),
		.out_side(dg_out)
	);

	assign csqb_c = cb_s10 * cb_s10;
	assign csqg_c = cg_s10 * cg_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s10 <= db_valid & dg_valid;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		cb_s10 <= arg_q14(qb, db_out.neg, db_out.over, db_out.dz);
		cg_s10 <= arg_q14(qg, dg_out.neg, dg_out.over, dg_out.dz);
		side_s10 <= db_out;
		over_g_s10 <= dg_out.over;

		csqb_s11 <= csqb_c[28:0];
		csqg_s11 <= csqg_c[28:0];
		cb_s11 <= cb_s10;
		cg_s11 <= cg_s10;
		side_s11 <= side_s10;
		over_g_s11 <= over_g_s10;

		radb_s12 <= ONE_SQ - csqb_s11;
		radg_s12 <= ONE_SQ - csqg_s11;
		sb_in.c <= cb_s11;
		sb_in.wx <= side_s11.wx;
		sb_in.wy <= side_s11.wy;
		sb_in.origin <= side_s11.origin;
		sb_in.over <= side_s11.over;
		sg_in.c <= cg_s11;
		sg_in.over <= over_g_s11;
	end

	tlik_isqrt #(
		.W(30),
		.SW($bits(sb_side_t))
	) u_sqrt_beta (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s12),
		.in_value({1'b0, radb_s12}),
		.in_side(sb_in),
		.out_valid(sb_valid),
		.root(sb_root),
		.out_side(sb_out)
	);

	tlik_isqrt #(
		.W(30),
		.SW($bits(sg_side_t))
	) u_sqrt_gamma (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s12),
		.in_value({1'b0, radg_s12}),
		.in_side(sg_in),
		.out_valid(sg_valid),
		.root(sg_root),
		.out_side(sg_out)
	);

	tlik_vecang #(
		.STEPS(CORDIC_STEPS),
		.IW(16),
		.SW(1)
	) u_ang_alpha (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sb_valid),
		.u(sb_out.wy),
		.v(sb_out.wx),
		.in_side(sb_out.origin),
		.out_valid(va_valid),
		.ang(alpha_ang),
		.out_side(va_origin)
	);

	tlik_vecang #(
		.STEPS(CORDIC_STEPS),
		.IW(16),
		.SW(1)
	) u_ang_beta (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sb_valid),
		.u(sb_out.c),
		.v($signed({1'b0, sb_root})),
		.in_side(sb_out.over),
		.out_valid(vb_valid),
		.ang(beta_ang),
		.out_side(vb_over)
	);

	tlik_vecang #(
		.STEPS(CORDIC_STEPS),
		.IW(16),
		.SW(1)
	) u_ang_gamma (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sg_valid),
		.u(sg_out.c),
		.v($signed({1'b0, sg_root})),
		.in_side(sg_out.over),
		.out_valid(vg_valid),
		.ang(gamma_ang),
		.out_side(vg_over)
	);

	assign elbow_c = PI_Q12 - gamma_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s13 <= va_valid & vb_valid & vg_valid;
			done <= vld_s13;
		end
	end

	always_ff @(posedge clk) begin
		alpha_s13 <= clamp16(alpha_ang, -PI_Q12, PI_Q12);
		beta_s13 <= clamp16(beta_ang, 16'sd0, PI_Q12);
		gamma_s13 <= clamp16(gamma_ang, 16'sd0, PI_Q12);
		origin_s13 <= va_origin;
		clamped_s13 <= vb_over | vg_over;

		if (origin_s13) begin
			shoulder_angle <= '0;
			elbow_angle <= '0;
			reach_status <= REACH_ORIGIN;
		end else begin
			shoulder_angle <= alpha_s13 - beta_s13;
			elbow_angle <= elbow_c[13:0];
			reach_status <= clamped_s13 ? REACH_CLAMPED : REACH_OK;
		end
	end

endmodule
